@@ src/dpfq_pkg.sv @@
// ----------------------------------------------------------------------------
// dpfq_pkg: shared types and constants of the dual-port frame queue
// Queue geometry, entry layout, request kinds and the DLC length decode.
// ----------------------------------------------------------------------------
package dpfq_pkg;

   localparam int QUEUE_DEPTH = 32;                       // slots per port ring
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int SLOT_COUNT  = 2 * QUEUE_DEPTH;
   localparam int SLOT_W      = $clog2(SLOT_COUNT);
   localparam int HDR_W       = 52;
   localparam int PAY_W       = 64;
   localparam int ENTRY_W     = HDR_W + PAY_W;
   localparam logic [15:0] DROP_MAX = 16'hFFFF;

   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [ENTRY_W-1:0] entry_type;

   typedef enum logic [1:0] {
      KIND_PUSH   = 2'd0,
      KIND_POP    = 2'd1,
      KIND_POP_RR = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   // status of one request as it leaves the queue control stage
   typedef struct packed {
      logic        accepted;
      logic        popped;
      logic        port;
      logic [1:0]  ready_flags;
      logic [15:0] dropped;
   } stage_type;

   function automatic ptr_type ring_next(input ptr_type p);
      ring_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_type'(p + 1'b1);
   endfunction

   function automatic slot_type slot_of(input logic q, input ptr_type p);
      slot_of = q ? slot_type'(SLOT_W'(QUEUE_DEPTH) + SLOT_W'(p)) : SLOT_W'(p);
   endfunction

   function automatic logic [6:0] dlc_len(input logic [3:0] dlc);
      logic [6:0] len;
      unique case (dlc)
         4'd9:    len = 7'd12;
         4'd10:   len = 7'd16;
         4'd11:   len = 7'd20;
         4'd12:   len = 7'd24;
         4'd13:   len = 7'd32;
         4'd14:   len = 7'd48;
         4'd15:   len = 7'd64;
         default: len = {3'b000, dlc};
      endcase
      dlc_len = len;
   endfunction

endpackage

@@ src/dpfq_store.sv @@
// ----------------------------------------------------------------------------
// dpfq_store: frame entry memory
// One write port, one read port with registered read data, both rings share it.
// ----------------------------------------------------------------------------
module dpfq_store (
   input  logic               clock,
   input  logic               wr_en,
   input  dpfq_pkg::slot_type  wr_addr,
   input  dpfq_pkg::entry_type wr_data,
   input  logic               rd_en,
   input  dpfq_pkg::slot_type  rd_addr,
   output dpfq_pkg::entry_type rd_data
);

   dpfq_pkg::entry_type store_ff [dpfq_pkg::SLOT_COUNT];
   dpfq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/dpfq_ctrl.sv @@
// ----------------------------------------------------------------------------
// dpfq_ctrl: ring pointer and flag control
// Decides push/pop per request, moves pointers, drives the memory, holds stage A.
// ----------------------------------------------------------------------------
module dpfq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                advance,
   input  logic [1:0]          req_kind,
   input  logic                req_port,
   input  logic [28:0]         req_frame_id,
   input  logic                req_id_extended,
   input  logic                req_fdf,
   input  logic                req_bit_rate_switch,
   input  logic [3:0]          req_len_code,
   input  logic [15:0]         req_rx_timestamp,
   input  logic [63:0]         req_payload,
   output logic                wr_en,
   output dpfq_pkg::slot_type  wr_addr,
   output dpfq_pkg::entry_type wr_data,
   output logic                rd_en,
   output dpfq_pkg::slot_type  rd_addr,
   output logic                a_valid,
   output dpfq_pkg::stage_type a_stage
);

   dpfq_pkg::ptr_type   wp_ff [2];
   dpfq_pkg::ptr_type   rp_ff [2];
   dpfq_pkg::ptr_type   wp_in [2];
   dpfq_pkg::ptr_type   rp_in [2];
   logic                nxt_ff, nxt_in;
   logic [1:0]          ready_ff, ready_in;
   logic [15:0]         drop_ff, drop_in;
   logic                a_valid_ff;
   dpfq_pkg::stage_type stage_ff, stage_in;
   logic                full, push_ok, pop_go, pop_q;
   logic [1:0]          empty;

   assign empty[0] = (wp_ff[0] == rp_ff[0]);
   assign empty[1] = (wp_ff[1] == rp_ff[1]);
   assign full     = (dpfq_pkg::ring_next(wp_ff[req_port]) == rp_ff[req_port]);

   always_comb begin
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      nxt_in   = nxt_ff;
      ready_in = ready_ff;
      drop_in  = drop_ff;
      push_ok  = 1'b0;
      pop_go   = 1'b0;
      pop_q    = 1'b0;
      unique case (dpfq_pkg::kind_type'(req_kind))
         dpfq_pkg::KIND_PUSH: begin
            if (full) begin
               if (drop_ff != dpfq_pkg::DROP_MAX) begin
                  drop_in = drop_ff + 16'd1;
               end
            end else begin
               push_ok          = 1'b1;
               wp_in[req_port]  = dpfq_pkg::ring_next(wp_ff[req_port]);
            end
            ready_in[req_port] = 1'b1;
         end
         dpfq_pkg::KIND_POP: begin
            if (empty[req_port]) begin
               ready_in[req_port] = 1'b0;
            end else begin
               pop_go = 1'b1;
               pop_q  = req_port;
            end
         end
         dpfq_pkg::KIND_POP_RR: begin
            if (!empty[nxt_ff]) begin
               pop_go = 1'b1;
               pop_q  = nxt_ff;
            end else begin
               ready_in[nxt_ff] = 1'b0;
               if (!empty[!nxt_ff]) begin
                  pop_go = 1'b1;
                  pop_q  = !nxt_ff;
               end else begin
                  ready_in[!nxt_ff] = 1'b0;
               end
            end
            if (pop_go) begin
               nxt_in = !pop_q;
            end
         end
         default: begin
         end
      endcase
      if (pop_go) begin
         rp_in[pop_q]    = dpfq_pkg::ring_next(rp_ff[pop_q]);
         ready_in[pop_q] = (dpfq_pkg::ring_next(rp_ff[pop_q]) != wp_ff[pop_q]);
      end
      stage_in.accepted    = push_ok | pop_go;
      stage_in.popped      = pop_go;
      stage_in.port        = pop_go & pop_q;
      stage_in.ready_flags = ready_in;
      stage_in.dropped     = drop_in;
   end

   assign wr_en   = accept & push_ok;
   assign wr_addr = dpfq_pkg::slot_of(req_port, wp_ff[req_port]);
   assign wr_data = {req_payload, req_rx_timestamp, req_len_code, req_bit_rate_switch,
                     req_fdf, req_id_extended, req_frame_id};
   assign rd_en   = accept & pop_go;
   assign rd_addr = dpfq_pkg::slot_of(pop_q, rp_ff[pop_q]);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff[0]   <= '0;
         wp_ff[1]   <= '0;
         rp_ff[0]   <= '0;
         rp_ff[1]   <= '0;
         nxt_ff     <= 1'b0;
         ready_ff   <= '0;
         drop_ff    <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            wp_ff    <= wp_in;
            rp_ff    <= rp_in;
            nxt_ff   <= nxt_in;
            ready_ff <= ready_in;
            drop_ff  <= drop_in;
         end
         if (accept) begin
            a_valid_ff <= 1'b1;
         end else if (advance) begin
            a_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign a_valid = a_valid_ff;
   assign a_stage = stage_ff;

endmodule

@@ src/dpfq_resp.sv @@
// ----------------------------------------------------------------------------
// dpfq_resp: response decode and output register
// Unpacks the read entry, decodes the DLC length, holds the response for rsp_ready.
// ----------------------------------------------------------------------------
module dpfq_resp (
   input  logic                clock,
   input  logic                reset,
   input  logic                a_valid,
   input  dpfq_pkg::stage_type a_stage,
   input  dpfq_pkg::entry_type rd_data,
   output logic                advance,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_accepted,
   output logic                rsp_out_port,
   output logic [28:0]         rsp_out_frame_id,
   output logic                rsp_out_id_extended,
   output logic                rsp_out_fdf,
   output logic                rsp_out_bit_rate_switch,
   output logic [3:0]          rsp_out_len_code,
   output logic [6:0]          rsp_length_bytes,
   output logic [15:0]         rsp_out_timestamp,
   output logic [63:0]         rsp_out_payload,
   output logic [1:0]          rsp_ready_flags,
   output logic [15:0]         rsp_dropped_frames
);

   logic                rsp_valid_ff;
   dpfq_pkg::entry_type frame;
   logic                accepted_ff, port_ff, ext_ff, fd_ff, brs_ff;
   logic [28:0]         id_ff;
   logic [3:0]          dlc_ff;
   logic [6:0]          len_ff;
   logic [15:0]         ts_ff, drop_ff;
   logic [63:0]         pay_ff;
   logic [1:0]          flags_ff;

   assign advance = a_valid & (~rsp_valid_ff | rsp_ready);
   // non-pop responses report zero frame fields
   assign frame   = a_stage.popped ? rd_data : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         accepted_ff <= a_stage.accepted;
         port_ff     <= a_stage.port;
         id_ff       <= frame[28:0];
         ext_ff      <= frame[29];
         fd_ff       <= frame[30];
         brs_ff      <= frame[31];
         dlc_ff      <= frame[35:32];
         len_ff      <= dpfq_pkg::dlc_len(frame[35:32]);
         ts_ff       <= frame[51:36];
         pay_ff      <= frame[115:52];
         flags_ff    <= a_stage.ready_flags;
         drop_ff     <= a_stage.dropped;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_accepted            = accepted_ff;
   assign rsp_out_port            = port_ff;
   assign rsp_out_frame_id        = id_ff;
   assign rsp_out_id_extended     = ext_ff;
   assign rsp_out_fdf             = fd_ff;
   assign rsp_out_bit_rate_switch = brs_ff;
   assign rsp_out_len_code        = dlc_ff;
   assign rsp_length_bytes        = len_ff;
   assign rsp_out_timestamp       = ts_ff;
   assign rsp_out_payload         = pay_ff;
   assign rsp_ready_flags         = flags_ff;
   assign rsp_dropped_frames      = drop_ff;

endmodule

@@ src/dual_port_frame_queue_round_robin.sv @@
// ----------------------------------------------------------------------------
// dual_port_frame_queue_round_robin: two received-frame rings with RR pop
// Per-port ring queues (one slot kept free), push with saturating drop count,
// named pop and round-robin pop, DLC length decode on every response.
// ----------------------------------------------------------------------------
//
//   channel  handshake           carries
//   -------  ------------------  ------------------------------------------
//   req      req_valid/ready     kind, port, frame header, timestamp, payload
//   rsp      rsp_valid/ready     accepted flag, popped frame, flags, drops
//
// One request per cycle while req_ready is high. A request is decided and the
// pointers move at the accept edge, which also loads the memory read into stage
// A; stage A loads the response register, raising rsp_valid, when that is free
// or read. These two registers part the two sides: one more request is taken
// while a response waits, then req_ready drops. Reset clears pointers, flags,
// counter and valid bits; entry memory is not cleared (read once written).
//
module dual_port_frame_queue_round_robin (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic        req_port,
   input  logic [28:0] req_frame_id,
   input  logic        req_id_extended,
   input  logic        req_fdf,
   input  logic        req_bit_rate_switch,
   input  logic [3:0]  req_len_code,
   input  logic [15:0] req_rx_timestamp,
   input  logic [63:0] req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic        rsp_out_port,
   output logic [28:0] rsp_out_frame_id,
   output logic        rsp_out_id_extended,
   output logic        rsp_out_fdf,
   output logic        rsp_out_bit_rate_switch,
   output logic [3:0]  rsp_out_len_code,
   output logic [6:0]  rsp_length_bytes,
   output logic [15:0] rsp_out_timestamp,
   output logic [63:0] rsp_out_payload,
   output logic [1:0]  rsp_ready_flags,
   output logic [15:0] rsp_dropped_frames
);

   logic                accept, advance, a_valid;
   logic                wr_en, rd_en;
   dpfq_pkg::slot_type  wr_addr, rd_addr;
   dpfq_pkg::entry_type wr_data, rd_data;
   dpfq_pkg::stage_type a_stage;

   // stage A frees up whenever it moves into the response register
   assign req_ready = ~a_valid | advance;
   assign accept    = req_valid & req_ready;

   dpfq_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .advance             (advance),
      .req_kind            (req_kind),
      .req_port            (req_port),
      .req_frame_id        (req_frame_id),
      .req_id_extended     (req_id_extended),
      .req_fdf             (req_fdf),
      .req_bit_rate_switch (req_bit_rate_switch),
      .req_len_code        (req_len_code),
      .req_rx_timestamp    (req_rx_timestamp),
      .req_payload         (req_payload),
      .wr_en               (wr_en),
      .wr_addr             (wr_addr),
      .wr_data             (wr_data),
      .rd_en               (rd_en),
      .rd_addr             (rd_addr),
      .a_valid             (a_valid),
      .a_stage             (a_stage)
   );

   // a push and a pop never meet on one slot in one cycle: one request per edge
   dpfq_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dpfq_resp u_resp (
      .clock                   (clock),
      .reset                   (reset),
      .a_valid                 (a_valid),
      .a_stage                 (a_stage),
      .rd_data                 (rd_data),
      .advance                 (advance),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_accepted            (rsp_accepted),
      .rsp_out_port            (rsp_out_port),
      .rsp_out_frame_id        (rsp_out_frame_id),
      .rsp_out_id_extended     (rsp_out_id_extended),
      .rsp_out_fdf             (rsp_out_fdf),
      .rsp_out_bit_rate_switch (rsp_out_bit_rate_switch),
      .rsp_out_len_code        (rsp_out_len_code),
      .rsp_length_bytes        (rsp_length_bytes),
      .rsp_out_timestamp       (rsp_out_timestamp),
      .rsp_out_payload         (rsp_out_payload),
      .rsp_ready_flags         (rsp_ready_flags),
      .rsp_dropped_frames      (rsp_dropped_frames)
   );

endmodule

@@ src/dpfq_checker.sv @@
// ----------------------------------------------------------------------------
// dpfq_checker: port-level checks of the dual-port frame queue
// Watches the response channel only; bound to the top level.
// ----------------------------------------------------------------------------
module dpfq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_accepted,
   input logic        rsp_out_port,
   input logic [3:0]  rsp_out_len_code,
   input logic [6:0]  rsp_length_bytes,
   input logic [63:0] rsp_out_payload,
   input logic [15:0] rsp_dropped_frames
);

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_payload)
         && $stable(rsp_dropped_frames))
      else $error("stalled response changed");

   // failed request carries no frame
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> !rsp_out_port && rsp_out_len_code == 4'd0
         && rsp_length_bytes == 7'd0 && rsp_out_payload == 64'd0)
      else $error("frame fields set on a failed request");

   // length decode agrees with the DLC
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_len_code <= 4'd8) ?
         (rsp_length_bytes == {3'b000, rsp_out_len_code}) :
         (rsp_length_bytes > 7'd8 && rsp_length_bytes <= 7'd64))
      else $error("length does not match DLC");

endmodule

bind dual_port_frame_queue_round_robin dpfq_checker u_dpfq_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_accepted       (rsp_accepted),
   .rsp_out_port       (rsp_out_port),
   .rsp_out_len_code   (rsp_out_len_code),
   .rsp_length_bytes   (rsp_length_bytes),
   .rsp_out_payload    (rsp_out_payload),
   .rsp_dropped_frames (rsp_dropped_frames)
);

@@ bench/frame_queue_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_queue_checker: response predictor and scoreboard for the frame queue
// Watches the request and response handshakes, keeps its own copy of both
// port rings, the ready flags, the round-robin pointer and the drop counter,
// and compares every response field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module frame_queue_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic        req_port,
   input  logic [28:0] req_frame_id,
   input  logic        req_id_extended,
   input  logic        req_fdf,
   input  logic        req_bit_rate_switch,
   input  logic [3:0]  req_len_code,
   input  logic [15:0] req_rx_timestamp,
   input  logic [63:0] req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_accepted,
   input  logic        rsp_out_port,
   input  logic [28:0] rsp_out_frame_id,
   input  logic        rsp_out_id_extended,
   input  logic        rsp_out_fdf,
   input  logic        rsp_out_bit_rate_switch,
   input  logic [3:0]  rsp_out_len_code,
   input  logic [6:0]  rsp_length_bytes,
   input  logic [15:0] rsp_out_timestamp,
   input  logic [63:0] rsp_out_payload,
   input  logic [1:0]  rsp_ready_flags,
   input  logic [15:0] rsp_dropped_frames,
   output int          mismatches,
   output int          outstanding,
   output int          replies_seen
);

   typedef struct packed {
      logic [28:0] frame_id;
      logic        id_extended;
      logic        fdf;
      logic        bit_rate_switch;
      logic [3:0]  len_code;
      logic [15:0] timestamp;
      logic [63:0] payload;
   } frame_rec_type;

   typedef struct packed {
      logic          accepted;
      logic          port;
      frame_rec_type frame;
      logic [6:0]    byte_len;
      logic [1:0]    ready_flags;
      logic [15:0]   dropped;
   } reply_type;

   // model of the two rings: slot array, oldest slot and frame count per port
   frame_rec_type slot_mem [2][dpfq_pkg::QUEUE_DEPTH];
   int            head [2];
   int            fill [2];
   logic [1:0]    ready_mask;
   logic          rr_next;
   logic [15:0]   drops;
   reply_type     pending_replies [$];

   function automatic logic [6:0] byte_count(input logic [3:0] dlc);
      logic [6:0] n;
      if (dlc <= 4'd8) n = {3'b000, dlc};
      else begin
         case (dlc)
            4'd9:    n = 7'd12;
            4'd10:   n = 7'd16;
            4'd11:   n = 7'd20;
            4'd12:   n = 7'd24;
            4'd13:   n = 7'd32;
            4'd14:   n = 7'd48;
            default: n = 7'd64;
         endcase
      end
      return n;
   endfunction

   task automatic take_frame(input logic p, output bit got, inout reply_type r);
      if (fill[p] == 0) begin
         ready_mask[p] = 1'b0;
         got = 1'b0;
      end else begin
         r.accepted = 1'b1;
         r.port     = p;
         r.frame    = slot_mem[p][head[p]];
         r.byte_len = byte_count(r.frame.len_code);
         head[p]    = (head[p] + 1) % dpfq_pkg::QUEUE_DEPTH;
         fill[p]--;
         ready_mask[p] = (fill[p] != 0);
         got = 1'b1;
      end
   endtask

   task automatic apply_request();
      reply_type     r;
      frame_rec_type f;
      bit            got;
      logic          p;
      r = '0;
      p = req_port;
      f = '{req_frame_id, req_id_extended, req_fdf, req_bit_rate_switch,
            req_len_code, req_rx_timestamp, req_payload};
      case (dpfq_pkg::kind_type'(req_kind))
         dpfq_pkg::KIND_PUSH: begin
            if (fill[p] == dpfq_pkg::QUEUE_DEPTH - 1) begin
               if (drops != dpfq_pkg::DROP_MAX) drops++;
            end else begin
               slot_mem[p][(head[p] + fill[p]) % dpfq_pkg::QUEUE_DEPTH] = f;
               fill[p]++;
               r.accepted = 1'b1;
            end
            ready_mask[p] = 1'b1;
         end
         dpfq_pkg::KIND_POP: take_frame(p, got, r);
         dpfq_pkg::KIND_POP_RR: begin
            got = 1'b0;
            for (int a = 0; a < 2; a++) begin
               logic q;
               q = rr_next ^ a[0];
               if (!got) begin
                  take_frame(q, got, r);
                  if (got) rr_next = ~q;
               end
            end
         end
         default: ;
      endcase
      r.ready_flags = ready_mask;
      r.dropped     = drops;
      pending_replies.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic compare_reply();
      reply_type want;
      if (pending_replies.size() == 0) begin
         $error("response with no request outstanding");
         mismatches++;
      end else begin
         want = pending_replies.pop_front();
         check_field("accepted", want.accepted, rsp_accepted);
         check_field("out_port", want.port, rsp_out_port);
         check_field("out_frame_id", want.frame.frame_id, rsp_out_frame_id);
         check_field("out_id_extended", want.frame.id_extended, rsp_out_id_extended);
         check_field("out_fdf", want.frame.fdf, rsp_out_fdf);
         check_field("out_bit_rate_switch", want.frame.bit_rate_switch,
                     rsp_out_bit_rate_switch);
         check_field("out_len_code", want.frame.len_code, rsp_out_len_code);
         check_field("length_bytes", want.byte_len, rsp_length_bytes);
         check_field("out_timestamp", want.frame.timestamp, rsp_out_timestamp);
         check_field("out_payload", want.frame.payload, rsp_out_payload);
         check_field("ready_flags", want.ready_flags, rsp_ready_flags);
         check_field("dropped_frames", want.dropped, rsp_dropped_frames);
         replies_seen++;
      end
   endtask

   initial begin
      mismatches   = 0;
      outstanding  = 0;
      replies_seen = 0;
   end

   // response side first: a response leaving at this edge is always older
   // than a request taken at the same edge
   always @(posedge clock) begin
      if (reset) begin
         head       = '{0, 0};
         fill       = '{0, 0};
         ready_mask = 2'b00;
         rr_next    = 1'b0;
         drops      = '0;
         pending_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_reply();
         if (req_valid && req_ready) apply_request();
      end
      outstanding <= pending_replies.size();
   end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the dual-port frame queue
// Drives push, named pop, round-robin pop and unused-kind requests with random
// idling on both channels, back pressure and drain pauses; the checker beside
// the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RANDOM_TARGET  = 880;     // requests sent before the full-ring run
   localparam int HOLDOFF_CYCLES = 60;      // receiver hold-off length
   localparam int FULL_PUSHES    = 40;      // back-to-back pushes overfilling port 0
   localparam int TAIL_CYCLES    = 8;       // covers the two register stages

   typedef struct packed {
      dpfq_pkg::kind_type kind;
      logic               port;
      logic [28:0]        frame_id;
      logic               id_extended;
      logic               fdf;
      logic               bit_rate_switch;
      logic [3:0]         len_code;
      logic [15:0]        rx_timestamp;
      logic [63:0]        payload;
   } frame_req_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_kind;
   logic        req_port;
   logic [28:0] req_frame_id;
   logic        req_id_extended;
   logic        req_fdf;
   logic        req_bit_rate_switch;
   logic [3:0]  req_len_code;
   logic [15:0] req_rx_timestamp;
   logic [63:0] req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_accepted;
   logic        rsp_out_port;
   logic [28:0] rsp_out_frame_id;
   logic        rsp_out_id_extended;
   logic        rsp_out_fdf;
   logic        rsp_out_bit_rate_switch;
   logic [3:0]  rsp_out_len_code;
   logic [6:0]  rsp_length_bytes;
   logic [15:0] rsp_out_timestamp;
   logic [63:0] rsp_out_payload;
   logic [1:0]  rsp_ready_flags;
   logic [15:0] rsp_dropped_frames;

   int mismatches;
   int outstanding;
   int replies_seen;

   // stimulus controls; rsp_idling and the hold-off counts are shared with rsp_side
   bit req_idling;
   bit rsp_idling;
   int holdoff_asked;
   int holdoff_served;
   int sent;
   int full_sent;

   dual_port_frame_queue_round_robin DUT (.*);

   frame_queue_checker checker_i (.*);

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Run limit. The slowest correct run (about a thousand requests, each with at
   // most a long gap and a long stall, plus the hold-off and drain pauses) stays
   // well inside it, leaving ample margin.
   initial begin
      #2_000_000;
      $display("dual_port_frame_queue_round_robin: mismatch");
      $finish;
   end

   // Idle length: mostly none, some short, a few long.
   function automatic int idle_len();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver: random stalls, plus the long hold-off when the sender asks.
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (holdoff_asked != holdoff_served) begin
            // long hold-off: the block fills its two stages and stalls req
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            holdoff_served++;
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_idling && $urandom_range(0, 99) < 25) stall_left = idle_len();
         end
      end
   end

   function automatic frame_req_type make_req(input dpfq_pkg::kind_type k, input logic p,
                                              input logic [28:0] id, input logic ext,
                                              input logic fd, input logic brs,
                                              input logic [3:0] dlc,
                                              input logic [15:0] ts,
                                              input logic [63:0] pl);
      frame_req_type r;
      r = '{k, p, id, ext, fd, brs, dlc, ts, pl};
      return r;
   endfunction

   // Request with all frame fields zero: pops, the unused kind and an all-zero push.
   function automatic frame_req_type bare_req(input dpfq_pkg::kind_type k, input logic p);
      return make_req(k, p, '0, 1'b0, 1'b0, 1'b0, 4'd0, '0, '0);
   endfunction

   // Random request; push share and port-1 share vary by segment so the
   // rings swing between empty and full.
   function automatic frame_req_type random_req(input int push_pct, input int port1_pct);
      frame_req_type r;
      int            roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) r.kind = dpfq_pkg::KIND_NONE;
      else if (roll < 3 + push_pct * 97 / 100) r.kind = dpfq_pkg::KIND_PUSH;
      else r.kind = $urandom_range(0, 1) ? dpfq_pkg::KIND_POP : dpfq_pkg::KIND_POP_RR;
      r.port            = ($urandom_range(0, 99) < port1_pct);
      r.id_extended     = 1'($urandom_range(0, 1));
      r.frame_id        = r.id_extended ? 29'($urandom) : 29'($urandom_range(0, 2047));
      r.fdf             = 1'($urandom_range(0, 1));
      r.bit_rate_switch = 1'($urandom_range(0, 1));
      r.len_code        = 4'($urandom_range(0, 15));
      r.rx_timestamp    = 16'($urandom);
      r.payload         = {$urandom, $urandom};
      return r;
   endfunction

   // Offer one request and hold it until the handshake completes. Called and
   // returning at a rising edge.
   task automatic offer(input frame_req_type r);
      int gap;
      gap = req_idling ? idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_kind            <= r.kind;
      req_port            <= r.port;
      req_frame_id        <= r.frame_id;
      req_id_extended     <= r.id_extended;
      req_fdf             <= r.fdf;
      req_bit_rate_switch <= r.bit_rate_switch;
      req_len_code        <= r.len_code;
      req_rx_timestamp    <= r.rx_timestamp;
      req_payload         <= r.payload;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   // Sender pause until every predicted response has come back. The count is
   // read at the falling edge, away from the checker's update.
   task automatic drain_all();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   initial begin : stimulus
      int seg_len;
      int push_pct;
      int port1_pct;
      req_valid           = 1'b0;
      req_kind            = dpfq_pkg::KIND_NONE;
      req_port            = 1'b0;
      req_frame_id        = '0;
      req_id_extended     = 1'b0;
      req_fdf             = 1'b0;
      req_bit_rate_switch = 1'b0;
      req_len_code        = '0;
      req_rx_timestamp    = '0;
      req_payload         = '0;
      reset               = 1'b1;
      req_idling          = 1'b0;
      rsp_idling          = 1'b0;
      holdoff_asked       = 0;
      holdoff_served      = 0;
      sent                = 0;
      full_sent           = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: empty pops, extremes, round-robin order -------------
      offer(bare_req(dpfq_pkg::KIND_POP, 1'b0));                  // empty named
      offer(bare_req(dpfq_pkg::KIND_POP, 1'b1));
      offer(bare_req(dpfq_pkg::KIND_POP_RR, 1'b0));               // both empty
      offer(make_req(dpfq_pkg::KIND_NONE, 1'b1, '1, 1'b1, 1'b1, 1'b1, 4'd15,
                     '1, '1));                                      // unused kind
      offer(make_req(dpfq_pkg::KIND_PUSH, 1'b0, '1, 1'b1, 1'b1, 1'b1, 4'd15,
                     '1, '1));                                      // all ones
      offer(bare_req(dpfq_pkg::KIND_PUSH, 1'b0));                 // all zeros
      offer(make_req(dpfq_pkg::KIND_PUSH, 1'b1, 29'h7FF, 1'b0, 1'b1, 1'b0, 4'd9,
                     16'h1234, 64'h0123_4567_89AB_CDEF));
      offer(make_req(dpfq_pkg::KIND_PUSH, 1'b1, 29'h155_5555, 1'b1, 1'b0, 1'b1, 4'd8,
                     16'h8001, 64'hA5A5_5A5A_F00F_0FF0));
      offer(bare_req(dpfq_pkg::KIND_POP_RR, 1'b1));               // serves port 0
      offer(bare_req(dpfq_pkg::KIND_POP_RR, 1'b0));               // serves port 1
      offer(bare_req(dpfq_pkg::KIND_POP_RR, 1'b0));               // port 0 empties
      offer(bare_req(dpfq_pkg::KIND_POP, 1'b1));                  // last of port 1
      offer(make_req(dpfq_pkg::KIND_PUSH, 1'b0, 29'h1, 1'b0, 1'b1, 1'b1, 4'd12,
                     16'h0001, 64'h8000_0000_0000_0001));
      offer(bare_req(dpfq_pkg::KIND_POP_RR, 1'b0));               // skips empty port 1
      offer(bare_req(dpfq_pkg::KIND_POP, 1'b0));                  // empty again
      offer(bare_req(dpfq_pkg::KIND_NONE, 1'b0));
      offer(make_req(dpfq_pkg::KIND_PUSH, 1'b1, 29'h0ABC_DEF, 1'b1, 1'b1, 1'b0, 4'd13,
                     16'hFFFE, 64'h0000_0000_FFFF_FFFF));
      offer(make_req(dpfq_pkg::KIND_PUSH, 1'b1, 29'h400, 1'b0, 1'b0, 1'b1, 4'd14,
                     16'h7FFF, 64'hFFFF_FFFF_0000_0000));
      offer(bare_req(dpfq_pkg::KIND_POP_RR, 1'b0));
      offer(bare_req(dpfq_pkg::KIND_POP, 1'b1));

      // ---- back pressure: receiver holds off while port 1 overfills ------
      drain_all();
      holdoff_asked++;
      repeat (40) offer(random_req(100, 100));
      rsp_idling = 1'b1;
      req_idling = 1'b1;
      repeat (36) offer(random_req(0, 100));
      drain_all();

      // ---- random segments: each with its own push share and port bias ---
      while (sent < RANDOM_TARGET) begin
         seg_len   = $urandom_range(10, 60);
         case ($urandom_range(0, 4))
            0:       push_pct = 10;
            1:       push_pct = 30;
            2:       push_pct = 50;
            3:       push_pct = 70;
            default: push_pct = 92;
         endcase
         port1_pct  = $urandom_range(0, 1) ? $urandom_range(0, 100) : 50;
         req_idling = ($urandom_range(0, 3) != 0);
         rsp_idling = ($urandom_range(0, 3) != 0);
         repeat (seg_len) offer(random_req(push_pct, port1_pct));
         if ($urandom_range(0, 7) == 0) drain_all();
      end

      // ---- full ring: port 0 fills, then pushes back to back are dropped -
      drain_all();
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      full_sent  = sent;
      repeat (FULL_PUSHES) offer(random_req(100, 0));
      full_sent  = sent - full_sent;
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      repeat (3) offer(random_req(0, 0));
      repeat (3) offer(random_req(100, 0));

      // ---- wind down ------------------------------------------------------
      drain_all();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d requests (%0d in the full-ring push run), %0d responses",
               sent, full_sent, replies_seen);
      $display("incl. empty and full rings, round-robin skips, hold-off and drain pauses");
      if (mismatches == 0) $display("dual_port_frame_queue_round_robin: match");
      else $display("dual_port_frame_queue_round_robin: mismatch");
      $finish;
   end

endmodule
